### sv/assert_macros.svh
// Assertion helpers shared by the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define BFX_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("bfx86 assertion failed");

`define BFX_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bfx86 implication failed");

`define BFX_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bfx86 next-cycle check failed");

`else

`define BFX_ASSERT(lbl, clk, rst, prop)
`define BFX_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define BFX_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

### sv/bfx86_pkg.sv
package bfx86_pkg;

   localparam int unsigned NEST_DEPTH     = 64;
   localparam int unsigned ADDR_BITS      = 24;
   localparam int unsigned DEPTH_BITS     = $clog2(NEST_DEPTH + 1);
   localparam int unsigned STACK_IDX_BITS = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
   localparam int unsigned MAX_RESULTS    = 13;
   localparam int unsigned COUNT_BITS     = $clog2(MAX_RESULTS + 1);
   localparam int unsigned OP_BYTES       = 9;
   localparam int unsigned OUT_ADDR_BITS  = 24;
   localparam int unsigned CODE_START_BITS  = 24;
   localparam int unsigned STACK_SPACE_BITS = 16;
   localparam int unsigned CSR_INDEX_BITS = 2;
   localparam int unsigned CSR_DATA_BITS  = 24;

   localparam logic [CODE_START_BITS-1:0]  CODE_START_RESET  = 24'd36;
   localparam logic [STACK_SPACE_BITS-1:0] STACK_SPACE_RESET = 16'd1024;
   localparam logic [ADDR_BITS-1:0]        HEADER_SIZE_ADDR  = ADDR_BITS'(16);

   localparam logic [CSR_INDEX_BITS-1:0] CSR_CODE_START  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STACK_SPACE = 2'd1;

   localparam logic [7:0] OP_NUL   = 8'h00;
   localparam logic [7:0] OP_RIGHT = 8'h3e;
   localparam logic [7:0] OP_LEFT  = 8'h3c;
   localparam logic [7:0] OP_INC   = 8'h2b;
   localparam logic [7:0] OP_DEC   = 8'h2d;
   localparam logic [7:0] OP_OUT   = 8'h2e;
   localparam logic [7:0] OP_IN    = 8'h2c;
   localparam logic [7:0] OP_OPEN  = 8'h5b;
   localparam logic [7:0] OP_CLOSE = 8'h5d;

   localparam logic [7:0] X86_ADD_EAX  = 8'h05;
   localparam logic [7:0] X86_SUB_EAX  = 8'h2d;
   localparam logic [7:0] X86_GRP1_B   = 8'h80;
   localparam logic [7:0] X86_MODRM_SUB = 8'h28;
   localparam logic [7:0] X86_MODRM_CMP = 8'h38;
   localparam logic [7:0] X86_TWO_BYTE = 8'h0f;
   localparam logic [7:0] X86_JE_NEAR  = 8'h84;
   localparam logic [7:0] X86_JMP_NEAR = 8'he9;
   localparam logic [7:0] X86_GRP5     = 8'hff;
   localparam logic [7:0] X86_CALL_EBX = 8'hd3;
   localparam logic [7:0] X86_CALL_ECX = 8'hd1;
   localparam logic [7:0] X86_RET      = 8'hc3;

   typedef enum logic [1:0] {
      JOB_OP,
      JOB_CLOSE,
      JOB_FINISH,
      JOB_ERROR
   } bfx86_job_type;

   typedef struct packed {
      logic                               err;
      logic [COUNT_BITS-1:0]              count;
      logic [COUNT_BITS-1:0]              split;
      logic [ADDR_BITS-1:0]               addr;
      logic [ADDR_BITS-1:0]               base1;
      logic [MAX_RESULTS-1:0][7:0]        bytes;
   } bfx86_load_type;

endpackage

### sv/bfx86_ram.sv
module bfx86_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/bfx86_emit.sv
`include "assert_macros.svh"

module bfx86_emit import bfx86_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load_valid,
   input  bfx86_load_type           load,
   output logic                     free,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [OUT_ADDR_BITS-1:0] rsp_address,
   output logic [7:0]               rsp_value,
   output logic                     rsp_error,
   output logic                     rsp_last
);

   logic                        valid_ff, valid_in;
   logic [MAX_RESULTS-1:0][7:0] bytes_ff, bytes_in;
   logic [ADDR_BITS-1:0]        addr_ff, addr_in;
   logic [ADDR_BITS-1:0]        base1_ff, base1_in;
   logic [COUNT_BITS-1:0]       split_ff, split_in;
   logic [COUNT_BITS-1:0]       cnt_ff, cnt_in;
   logic                        err_ff, err_in;
   logic                        adv;
   logic                        done;

   assign adv  = valid_ff && !rsp_stall;
   assign done = adv && (cnt_ff == COUNT_BITS'(1));
   assign free = !valid_ff || done;

   always_comb begin
      valid_in = valid_ff;
      bytes_in = bytes_ff;
      addr_in  = addr_ff;
      base1_in = base1_ff;
      split_in = split_ff;
      cnt_in   = cnt_ff;
      err_in   = err_ff;
      priority if (load_valid) begin
         valid_in = 1'b1;
         bytes_in = load.bytes;
         addr_in  = load.addr;
         base1_in = load.base1;
         split_in = load.split;
         cnt_in   = load.count;
         err_in   = load.err;
      end else if (done) begin
         valid_in = 1'b0;
      end else if (adv) begin
         // advance to the next byte; jump to the second region at the split
         bytes_in = bytes_ff >> 8;
         cnt_in   = cnt_ff - COUNT_BITS'(1);
         addr_in  = (split_ff == COUNT_BITS'(1)) ? base1_ff : addr_ff + ADDR_BITS'(1);
         split_in = (split_ff != '0) ? split_ff - COUNT_BITS'(1) : split_ff;
      end else begin
         // hold
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         cnt_ff   <= '0;
         split_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         cnt_ff   <= cnt_in;
         split_ff <= split_in;
      end
      bytes_ff <= bytes_in;
      addr_ff  <= addr_in;
      base1_ff <= base1_in;
      err_ff   <= err_in;
   end

   assign rsp_valid   = valid_ff;
   assign rsp_address = OUT_ADDR_BITS'(addr_ff);
   assign rsp_value   = bytes_ff[0];
   assign rsp_error   = err_ff;
   assign rsp_last    = (cnt_ff == COUNT_BITS'(1));

   `BFX_ASSERT_IMP(a_emit_cnt_nonzero, clock, reset, valid_ff, cnt_ff != '0)
   `BFX_ASSERT_IMP(a_emit_load_when_free, clock, reset, load_valid, free)
   `BFX_ASSERT_NEXT(a_emit_hold_valid, clock, reset, adv && !done, valid_ff)

endmodule

### sv/bf_to_x86_code_emitter.sv
// Translates run-length compressed Brainfuck ops into x86 machine code, given as a stream
// of (address, byte) writes into an output image; an op request is decoded into a holding
// register and its bytes then leave one per cycle while rsp_stall is low: two bytes for '.'
// and ',', three for '+' and '-', five for '>' and '<', nine for '[' and ']', thirteen for a
// finish request and one for an error. The output is a single byte-write port; decoding of
// the next request overlaps the output of the current one, a NUL op is taken at the input
// and gives no result unless an error is pending, and the first byte of a request reaches
// the result port through the holding register and then the emitter register. Write
// code_start or stack_space only while idle.
`include "assert_macros.svh"

module bf_to_x86_code_emitter import bfx86_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_kind,
   input  logic [7:0]                req_op_char,
   input  logic [7:0]                req_amount,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [OUT_ADDR_BITS-1:0]  rsp_address,
   output logic [7:0]                rsp_value,
   output logic                      rsp_error,
   output logic                      rsp_last,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   logic [CODE_START_BITS-1:0]  code_start_ff, code_start_in;
   logic [STACK_SPACE_BITS-1:0] stack_space_ff, stack_space_in;
   logic [ADDR_BITS-1:0]        wp_ff, wp_in;
   logic [DEPTH_BITS-1:0]       depth_ff, depth_in;
   logic                        failed_ff, failed_in;

   logic                        st1_valid_ff, st1_valid_in;
   bfx86_job_type               st1_job_ff, st1_job_in;
   logic [COUNT_BITS-1:0]       st1_count_ff, st1_count_in;
   logic [OP_BYTES-1:0][7:0]    st1_bytes_ff, st1_bytes_in;
   logic [ADDR_BITS-1:0]        st1_wp_ff, st1_wp_in;
   logic [ADDR_BITS-1:0]        st1_end_ff, st1_end_in;

   logic                        acc;
   logic                        csr_wr;
   logic                        move;
   logic                        emit_free;
   logic                        dec_load;
   bfx86_job_type               dec_job;
   logic [COUNT_BITS-1:0]       dec_count;
   logic [OP_BYTES-1:0][7:0]    dec_bytes;
   logic [ADDR_BITS-1:0]        dec_end;

   logic                        ram_we;
   logic                        ram_re;
   logic [STACK_IDX_BITS-1:0]   ram_wr_addr;
   logic [STACK_IDX_BITS-1:0]   ram_rd_addr;
   logic [ADDR_BITS-1:0]        loop_begin;

   logic [31:0]                 begin32;
   logic [31:0]                 end32;
   logic [31:0]                 disp_back;
   logic [31:0]                 disp_fwd;
   logic [31:0]                 mem_need;
   bfx86_load_type              load;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;
   assign move      = st1_valid_ff && emit_free;
   assign req_stall = st1_valid_ff && !move;
   assign acc       = req_valid && !req_stall;

   assign ram_wr_addr = depth_ff[STACK_IDX_BITS-1:0];
   assign ram_rd_addr = STACK_IDX_BITS'(depth_ff - DEPTH_BITS'(1));

   // decode and state update
   always_comb begin
      code_start_in  = code_start_ff;
      stack_space_in = stack_space_ff;
      wp_in          = wp_ff;
      depth_in       = depth_ff;
      failed_in      = failed_ff;
      dec_load       = 1'b0;
      dec_job        = JOB_ERROR;
      dec_count      = COUNT_BITS'(1);
      dec_bytes      = '0;
      dec_end        = wp_ff;
      ram_we         = 1'b0;
      ram_re         = 1'b0;

      if (csr_wr && (csr_index == CSR_STACK_SPACE)) begin
         stack_space_in = csr_wdata[STACK_SPACE_BITS-1:0];
      end

      priority if (csr_wr && (csr_index == CSR_CODE_START)) begin
         code_start_in = csr_wdata[CODE_START_BITS-1:0];
         wp_in         = ADDR_BITS'(csr_wdata[CODE_START_BITS-1:0]);
         depth_in      = '0;
         failed_in     = 1'b0;
      end else if (acc && req_kind) begin
         dec_load = 1'b1;
         if (!failed_ff) begin
            dec_job   = JOB_FINISH;
            dec_count = COUNT_BITS'(MAX_RESULTS);
            dec_end   = wp_ff + ADDR_BITS'(1);
         end
         wp_in     = ADDR_BITS'(code_start_ff);
         depth_in  = '0;
         failed_in = 1'b0;
      end else if (acc && failed_ff) begin
         dec_load = 1'b1;
      end else if (acc) begin
         unique case (req_op_char)
            OP_RIGHT, OP_LEFT: begin
               dec_load     = 1'b1;
               dec_job      = JOB_OP;
               dec_count    = COUNT_BITS'(5);
               dec_bytes[0] = (req_op_char == OP_RIGHT) ? X86_ADD_EAX : X86_SUB_EAX;
               dec_bytes[1] = req_amount;
               wp_in        = wp_ff + ADDR_BITS'(5);
            end
            OP_INC, OP_DEC: begin
               dec_load     = 1'b1;
               dec_job      = JOB_OP;
               dec_count    = COUNT_BITS'(3);
               dec_bytes[0] = X86_GRP1_B;
               dec_bytes[1] = (req_op_char == OP_DEC) ? X86_MODRM_SUB : 8'h00;
               dec_bytes[2] = req_amount;
               wp_in        = wp_ff + ADDR_BITS'(3);
            end
            OP_OUT, OP_IN: begin
               dec_load     = 1'b1;
               dec_job      = JOB_OP;
               dec_count    = COUNT_BITS'(2);
               dec_bytes[0] = X86_GRP5;
               dec_bytes[1] = (req_op_char == OP_OUT) ? X86_CALL_EBX : X86_CALL_ECX;
               wp_in        = wp_ff + ADDR_BITS'(2);
            end
            OP_OPEN: begin
               dec_load = 1'b1;
               if (depth_ff == DEPTH_BITS'(NEST_DEPTH)) begin
                  failed_in = 1'b1;
               end else begin
                  ram_we       = 1'b1;
                  depth_in     = depth_ff + DEPTH_BITS'(1);
                  dec_job      = JOB_OP;
                  dec_count    = COUNT_BITS'(OP_BYTES);
                  dec_bytes[0] = X86_GRP1_B;
                  dec_bytes[1] = X86_MODRM_CMP;
                  dec_bytes[3] = X86_TWO_BYTE;
                  dec_bytes[4] = X86_JE_NEAR;
                  wp_in        = wp_ff + ADDR_BITS'(OP_BYTES);
               end
            end
            OP_CLOSE: begin
               dec_load = 1'b1;
               if (depth_ff == '0) begin
                  failed_in = 1'b1;
               end else begin
                  ram_re    = 1'b1;
                  depth_in  = depth_ff - DEPTH_BITS'(1);
                  dec_job   = JOB_CLOSE;
                  dec_count = COUNT_BITS'(OP_BYTES);
                  dec_end   = wp_ff + ADDR_BITS'(1);
                  wp_in     = wp_ff + ADDR_BITS'(5);
               end
            end
            OP_NUL: begin
               dec_load = 1'b0;
            end
            default: begin
               dec_load  = 1'b1;
               failed_in = 1'b1;
            end
         endcase
      end else begin
         // hold
      end
   end

   // hold the decoded request until the emitter takes it
   always_comb begin
      st1_valid_in = st1_valid_ff;
      st1_job_in   = st1_job_ff;
      st1_count_in = st1_count_ff;
      st1_bytes_in = st1_bytes_ff;
      st1_wp_in    = st1_wp_ff;
      st1_end_in   = st1_end_ff;
      if (acc && dec_load) begin
         st1_valid_in = 1'b1;
         st1_job_in   = dec_job;
         st1_count_in = dec_count;
         st1_bytes_in = dec_bytes;
         st1_wp_in    = wp_ff;
         st1_end_in   = dec_end;
      end else if (move) begin
         st1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_start_ff  <= CODE_START_RESET;
         stack_space_ff <= STACK_SPACE_RESET;
         wp_ff          <= ADDR_BITS'(CODE_START_RESET);
         depth_ff       <= '0;
         failed_ff      <= 1'b0;
         st1_valid_ff   <= 1'b0;
      end else begin
         code_start_ff  <= code_start_in;
         stack_space_ff <= stack_space_in;
         wp_ff          <= wp_in;
         depth_ff       <= depth_in;
         failed_ff      <= failed_in;
         st1_valid_ff   <= st1_valid_in;
      end
      st1_job_ff   <= st1_job_in;
      st1_count_ff <= st1_count_in;
      st1_bytes_ff <= st1_bytes_in;
      st1_wp_ff    <= st1_wp_in;
      st1_end_ff   <= st1_end_in;
   end

   bfx86_ram #(
      .WIDTH (ADDR_BITS),
      .DEPTH (NEST_DEPTH)
   ) u_loop_starts (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (wp_ff),
      .rd_en   (ram_re),
      .rd_addr (ram_rd_addr),
      .rd_data (loop_begin)
   );

   // build the emitter job: displacements and header words
   assign begin32   = 32'(loop_begin);
   assign end32     = (st1_job_ff == JOB_CLOSE) ? 32'(st1_end_ff) + 32'd4 : 32'(st1_end_ff);
   assign disp_back = begin32 - end32;
   assign disp_fwd  = end32 - begin32 - 32'd9;
   assign mem_need  = end32 + 32'(stack_space_ff);

   always_comb begin
      load       = '0;
      load.addr  = st1_wp_ff;
      load.base1 = st1_wp_ff;
      load.count = st1_count_ff;
      unique case (st1_job_ff)
         JOB_OP: begin
            load.bytes = (MAX_RESULTS * 8)'(st1_bytes_ff);
         end
         JOB_CLOSE: begin
            load.split    = COUNT_BITS'(5);
            load.base1    = loop_begin + ADDR_BITS'(5);
            load.bytes[0] = X86_JMP_NEAR;
            load.bytes[1] = disp_back[7:0];
            load.bytes[2] = disp_back[15:8];
            load.bytes[3] = disp_back[23:16];
            load.bytes[4] = disp_back[31:24];
            load.bytes[5] = disp_fwd[7:0];
            load.bytes[6] = disp_fwd[15:8];
            load.bytes[7] = disp_fwd[23:16];
            load.bytes[8] = disp_fwd[31:24];
         end
         JOB_FINISH: begin
            load.split     = COUNT_BITS'(1);
            load.base1     = HEADER_SIZE_ADDR;
            load.bytes[0]  = X86_RET;
            load.bytes[1]  = end32[7:0];
            load.bytes[2]  = end32[15:8];
            load.bytes[3]  = end32[23:16];
            load.bytes[4]  = end32[31:24];
            load.bytes[5]  = mem_need[7:0];
            load.bytes[6]  = mem_need[15:8];
            load.bytes[7]  = mem_need[23:16];
            load.bytes[8]  = mem_need[31:24];
            load.bytes[9]  = mem_need[7:0];
            load.bytes[10] = mem_need[15:8];
            load.bytes[11] = mem_need[23:16];
            load.bytes[12] = mem_need[31:24];
         end
         JOB_ERROR: begin
            load.err   = 1'b1;
            load.addr  = '0;
            load.count = COUNT_BITS'(1);
         end
         default: begin
            load.err = 1'b1;
         end
      endcase
   end

   bfx86_emit u_emit (
      .clock       (clock),
      .reset       (reset),
      .load_valid  (move),
      .load        (load),
      .free        (emit_free),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_address (rsp_address),
      .rsp_value   (rsp_value),
      .rsp_error   (rsp_error),
      .rsp_last    (rsp_last)
   );

   `BFX_ASSERT_IMP(a_error_result_shape, clock, reset, rsp_valid && rsp_error,
                   rsp_last && (rsp_address == '0) && (rsp_value == 8'h00))
   `BFX_ASSERT(a_depth_bound, clock, reset, depth_ff <= DEPTH_BITS'(NEST_DEPTH))
   `BFX_ASSERT_NEXT(a_failed_holds_state, clock, reset, acc && failed_ff && !req_kind && !csr_wr,
                    $stable(wp_ff) && $stable(depth_ff) && failed_ff)

endmodule
